// ----- hw/rtl/pca_pkg.sv -----
// Shared types and constants for the programmable counter array.
package pca_pkg;

   localparam int ModuleCount    = 5;
   localparam int FlagWidth      = ModuleCount + 1;
   localparam int CountWidth     = 16;
   localparam int ModeBits       = 5;
   localparam int ModeWidth      = ModuleCount * ModeBits;
   localparam int WatchdogModule = 4;
   localparam int FastCounts     = 3;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = ModeWidth;

   // bit positions inside one module's mode group
   localparam int MbPwm    = 0;
   localparam int MbToggle = 1;
   localparam int MbCapNeg = 2;
   localparam int MbCapPos = 3;
   localparam int MbCmpEn  = 4;

   localparam logic [ModeWidth-1:0] ModuleModesReset = ModeWidth'(17318416);

   typedef enum logic [1:0] {
      ModeTick       = 2'd0,
      ModeWriteCmp   = 2'd1,
      ModeWriteFlags = 2'd2,
      ModeLoadCount  = 2'd3
   } pca_mode_type;

   typedef enum logic [1:0] {
      ClkCycle  = 2'd0,
      ClkFast   = 2'd1,
      ClkTimer0 = 2'd2,
      ClkExtPin = 2'd3
   } pca_clk_src_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrCounterRun     = 3'd0,
      CsrIdleStop       = 3'd1,
      CsrClockSource    = 3'd2,
      CsrWatchdogEnable = 3'd3,
      CsrModuleModes    = 3'd4
   } pca_csr_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        timer0_overflowed;
      logic        external_clock_pin;
      logic [4:0]  module_pins;
      logic        cpu_idle;
      logic [2:0]  module_select;
      logic [15:0] write_value;
   } pca_req_type;

   typedef struct packed {
      logic [15:0] counter_value;
      logic [5:0]  status_flags;
      logic [4:0]  module_outputs;
      logic        watchdog_reset;
   } pca_rsp_type;

   typedef struct packed {
      logic                 counter_run;
      logic                 idle_stop;
      pca_clk_src_type      clock_source;
      logic                 watchdog_enable;
      logic [ModeWidth-1:0] module_modes;
   } pca_cfg_type;

   typedef struct packed {
      logic [CountWidth-1:0]                  count;
      logic [ModuleCount-1:0][CountWidth-1:0] cmp;
      logic [FlagWidth-1:0]                   flags;
      logic [ModuleCount-1:0]                 outs;
   } pca_state_type;

endpackage

// ----- hw/rtl/pca_count_step.sv -----
// One counter increment followed by the compare and PWM checks of every compare-enabled module.
module pca_count_step
   import pca_pkg::*;
(
   input  logic          enable,
   input  pca_cfg_type   cfg,
   input  pca_state_type st_in,
   output pca_state_type st_out,
   output logic          wd_hit
);

   always_comb begin
      st_out = st_in;
      wd_hit = 1'b0;
      if (enable) begin
         st_out.count = st_in.count + CountWidth'(1);
         if (st_out.count == '0) begin
            st_out.flags[0] = 1'b1;
         end
         for (int n = 0; n < ModuleCount; n++) begin
            if (cfg.module_modes[ModeBits*n + MbCmpEn]) begin
               if (st_out.count == st_out.cmp[n]) begin
                  st_out.flags[n+1] = 1'b1;
                  if (n == WatchdogModule && cfg.watchdog_enable) begin
                     wd_hit = 1'b1;
                  end
                  if (cfg.module_modes[ModeBits*n + MbToggle]) begin
                     st_out.outs[n] = ~st_out.outs[n];
                  end
               end
               // 8-bit PWM: reload low compare byte at the start of each low-byte period
               if (cfg.module_modes[ModeBits*n + MbPwm]) begin
                  if (st_out.count[7:0] == 8'd0) begin
                     st_out.cmp[n][7:0] = st_out.cmp[n][15:8];
                  end
                  st_out.outs[n] = (st_out.count[7:0] >= st_out.cmp[n][7:0]);
               end
            end
         end
      end
   end

endmodule

// ----- hw/rtl/pca_core.sv -----
// Counter array state and the execution of one item per cycle in which fire is asserted.
module pca_core
   import pca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  pca_req_type item,
   input  pca_cfg_type cfg,
   output pca_rsp_type result
);

   pca_state_type          st_ff, st_in;
   logic [ModuleCount-1:0] last_pins_ff, last_pins_in;
   logic                   last_clk_ff, last_clk_in;

   pca_state_type          pre_st;
   pca_state_type          chain [FastCounts+1];
   logic [FastCounts-1:0]  step_wd;
   logic [1:0]             counts;
   logic                   tick;
   logic [ModuleCount-1:0] pins;

   assign tick = (item.mode == ModeTick);
   assign pins = item.module_pins[ModuleCount-1:0];

   // captures and register writes, ahead of any counting
   always_comb begin
      pre_st = st_ff;
      case (item.mode)
         ModeTick: begin
            for (int n = 0; n < ModuleCount; n++) begin
               if ((cfg.module_modes[ModeBits*n + MbCapPos] && !last_pins_ff[n] && pins[n]) ||
                   (cfg.module_modes[ModeBits*n + MbCapNeg] && last_pins_ff[n] && !pins[n]))
               begin
                  pre_st.cmp[n]      = st_ff.count;
                  pre_st.flags[n+1]  = 1'b1;
               end
            end
         end
         ModeWriteCmp: begin
            for (int n = 0; n < ModuleCount; n++) begin
               if (item.module_select == 3'(n)) begin
                  pre_st.cmp[n] = item.write_value;
               end
            end
         end
         ModeWriteFlags: begin
            pre_st.flags = item.write_value[FlagWidth-1:0];
         end
         ModeLoadCount: begin
            pre_st.count = item.write_value;
         end
         default: begin
            pre_st = st_ff;
         end
      endcase
   end

   always_comb begin
      counts = 2'd0;
      if (tick && cfg.counter_run && !(cfg.idle_stop && item.cpu_idle)) begin
         case (cfg.clock_source)
            ClkCycle:  counts = 2'd1;
            ClkFast:   counts = 2'(FastCounts);
            ClkTimer0: counts = {1'b0, item.timer0_overflowed};
            ClkExtPin: counts = {1'b0, last_clk_ff && !item.external_clock_pin};
            default:   counts = 2'd0;
         endcase
      end
   end

   assign chain[0] = pre_st;

   for (genvar k = 0; k < FastCounts; k++) begin : g_step
      pca_count_step u_step (
         .enable (counts > 2'(k)),
         .cfg    (cfg),
         .st_in  (chain[k]),
         .st_out (chain[k+1]),
         .wd_hit (step_wd[k])
      );
   end

   always_comb begin
      st_in        = st_ff;
      last_pins_in = last_pins_ff;
      last_clk_in  = last_clk_ff;
      if (fire) begin
         st_in = chain[FastCounts];
         if (tick) begin
            last_pins_in = pins;
            last_clk_in  = item.external_clock_pin;
         end
      end
   end

   always_comb begin
      result.counter_value  = chain[FastCounts].count;
      result.status_flags   = 6'(chain[FastCounts].flags);
      result.module_outputs = 5'(chain[FastCounts].outs);
      result.watchdog_reset = |step_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.count  <= '0;
         st_ff.cmp    <= '0;
         st_ff.flags  <= '0;
         st_ff.outs   <= '1;
         last_pins_ff <= '1;
         last_clk_ff  <= 1'b1;
      end else begin
         st_ff        <= st_in;
         last_pins_ff <= last_pins_in;
         last_clk_ff  <= last_clk_in;
      end
   end

endmodule

// ----- hw/rtl/pca_counter_capture_compare_unit.sv -----
// Top level of the counter array: handshakes, configuration registers, result register.
// A request beat executes from the input register; its response is offered in the cycle after.
// Throughput: one request per cycle unless rsp_stall holds the response; the whole item settles
//   in one pass through up to three chained count stages from input to response register.
// Reset (synchronous, active high): counter, compare words and flags clear, output levels and
//   pin history go high, configuration returns to compare-enable only, both channels empty.
module pca_counter_capture_compare_unit
   import pca_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pca_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pca_rsp_type              rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   pca_cfg_type cfg_ff, cfg_in;
   logic        in_valid_ff, in_valid_in;
   pca_req_type in_data_ff, in_data_in;
   logic        out_valid_ff, out_valid_in;
   pca_rsp_type out_data_ff, out_data_in;
   pca_rsp_type result;
   logic        fire;
   logic        req_take;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   pca_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (pca_csr_type'(csr_index))
            CsrCounterRun:     cfg_in.counter_run     = csr_wdata[0];
            CsrIdleStop:       cfg_in.idle_stop       = csr_wdata[0];
            CsrClockSource:    cfg_in.clock_source    = pca_clk_src_type'(csr_wdata[1:0]);
            CsrWatchdogEnable: cfg_in.watchdog_enable = csr_wdata[0];
            CsrModuleModes:    cfg_in.module_modes    = csr_wdata[ModeWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (fire) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_run     <= 1'b0;
         cfg_ff.idle_stop       <= 1'b0;
         cfg_ff.clock_source    <= ClkCycle;
         cfg_ff.watchdog_enable <= 1'b0;
         cfg_ff.module_modes    <= ModuleModesReset;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the programmable counter array top level.
module tb;
   import pca_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int GapPct     = 24;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   pca_req_type              req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   pca_rsp_type              rsp_data;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CsrCounterRun;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   pca_counter_capture_compare_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted state of the counter array
   pca_cfg_type      cfg_m = '{1'b0, 1'b0, ClkCycle, 1'b0, ModuleModesReset};
   logic [15:0]      count_m = '0;
   logic [15:0]      cmp_m [ModuleCount] = '{default: '0};
   logic [5:0]       flags_m = '0;
   logic [4:0]       outs_m = '1;
   logic [4:0]       pins_m = '1;
   logic             clkpin_m = 1'b1;

   pca_req_type      req_items [$];
   pca_rsp_type      pca_outcomes [$];
   bit               req_took = 1'b0;
   bit               quiet = 1'b0;
   int               beats_sent = 0;
   int               beats_in = 0;
   int               beats_out = 0;
   int               mismatches = 0;
   int               cycle_cnt = 0;
   int               ticks_seen = 0;
   int               count_steps = 0;
   int               wd_seen = 0;
   int               settings_run = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_bad(input string msg);
      if (mismatches < 40) $display("ERROR @%0d: %s", cycle_cnt, msg);
      mismatches++;
   endtask

   // one count of the counter, then compare and PWM in every compare-enabled module
   task automatic count_one(inout logic wd);
      logic [4:0] grp;
      count_m = count_m + 16'd1;
      count_steps++;
      if (count_m == 16'd0) flags_m[0] = 1'b1;
      for (int n = 0; n < ModuleCount; n++) begin
         grp = cfg_m.module_modes[n*ModeBits +: ModeBits];
         if (grp[MbCmpEn]) begin
            if (count_m == cmp_m[n]) begin
               flags_m[n+1] = 1'b1;
               if (n == WatchdogModule && cfg_m.watchdog_enable) wd = 1'b1;
               if (grp[MbToggle]) outs_m[n] = ~outs_m[n];
            end
            if (grp[MbPwm]) begin
               if (count_m[7:0] == 8'd0) cmp_m[n][7:0] = cmp_m[n][15:8];
               outs_m[n] = !(count_m[7:0] < cmp_m[n][7:0]);
            end
         end
      end
   endtask

   task automatic next_pca_state(input pca_req_type r, output pca_rsp_type o);
      logic [4:0] grp;
      logic       wd;
      int         steps;
      wd = 1'b0;
      steps = 0;
      case (pca_mode_type'(r.mode))
         ModeTick: begin
            ticks_seen++;
            // capture uses the count from before this tick
            for (int n = 0; n < ModuleCount; n++) begin
               grp = cfg_m.module_modes[n*ModeBits +: ModeBits];
               if ((grp[MbCapPos] && !pins_m[n] && r.module_pins[n]) ||
                   (grp[MbCapNeg] && pins_m[n] && !r.module_pins[n])) begin
                  cmp_m[n] = count_m;
                  flags_m[n+1] = 1'b1;
               end
            end
            if (cfg_m.counter_run && !(cfg_m.idle_stop && r.cpu_idle)) begin
               case (cfg_m.clock_source)
                  ClkCycle:  steps = 1;
                  ClkFast:   steps = FastCounts;
                  ClkTimer0: steps = r.timer0_overflowed;
                  default:   steps = clkpin_m && !r.external_clock_pin;
               endcase
            end
            repeat (steps) count_one(wd);
            pins_m = r.module_pins;
            clkpin_m = r.external_clock_pin;
         end
         ModeWriteCmp: begin
            if (r.module_select < ModuleCount) cmp_m[r.module_select] = r.write_value;
         end
         ModeWriteFlags: flags_m = r.write_value[FlagWidth-1:0];
         default: count_m = r.write_value;
      endcase
      if (wd) wd_seen++;
      o.counter_value  = count_m;
      o.status_flags   = flags_m;
      o.module_outputs = outs_m;
      o.watchdog_reset = wd;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_items.size() != 0 && (quiet || $urandom_range(99) >= GapPct)) begin
            req_data  <= req_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < GapPct);
   end

   // predict on accepted request beats, check accepted response beats
   always @(posedge clock) begin
      pca_rsp_type want;
      pca_rsp_type got;
      cycle_cnt++;
      req_took = !reset && req_valid && !req_stall;
      if (req_took) begin
         next_pca_state(req_data, want);
         pca_outcomes.push_back(want);
         beats_in++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         beats_out++;
         if (pca_outcomes.size() == 0) begin
            report_bad($sformatf("response beat %0d with nothing pending", beats_out));
         end else begin
            want = pca_outcomes.pop_front();
            if (got.counter_value !== want.counter_value)
               report_bad($sformatf("beat %0d counter_value %h, predicted %h",
                                    beats_out, got.counter_value, want.counter_value));
            if (got.status_flags !== want.status_flags)
               report_bad($sformatf("beat %0d status_flags %h, predicted %h",
                                    beats_out, got.status_flags, want.status_flags));
            if (got.module_outputs !== want.module_outputs)
               report_bad($sformatf("beat %0d module_outputs %h, predicted %h",
                                    beats_out, got.module_outputs, want.module_outputs));
            if (got.watchdog_reset !== want.watchdog_reset)
               report_bad($sformatf("beat %0d watchdog_reset %b, predicted %b",
                                    beats_out, got.watchdog_reset, want.watchdog_reset));
         end
      end
      if (cycle_cnt >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses still pending",
                  cycle_cnt, pca_outcomes.size());
         $display("pca_counter_capture_compare_unit: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input pca_csr_type idx, input logic [CsrDataWidth-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic program_csrs(input pca_cfg_type c);
      csr_write(CsrCounterRun, CsrDataWidth'(c.counter_run));
      csr_write(CsrIdleStop, CsrDataWidth'(c.idle_stop));
      csr_write(CsrClockSource, CsrDataWidth'(c.clock_source));
      csr_write(CsrWatchdogEnable, CsrDataWidth'(c.watchdog_enable));
      csr_write(CsrModuleModes, c.module_modes);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_m = c;
      settings_run++;
   endtask

   task automatic wait_drained();
      while (beats_in != beats_sent || pca_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_beat(input pca_req_type r);
      req_items.push_back(r);
      beats_sent++;
   endtask

   function automatic pca_req_type beat_of(input pca_mode_type m, input logic [2:0] sel,
                                           input logic [15:0] val, input logic [4:0] pins,
                                           input logic ext, input logic t0, input logic idle);
      pca_req_type r;
      r.mode               = m;
      r.module_select      = sel;
      r.write_value        = val;
      r.module_pins        = pins;
      r.external_clock_pin = ext;
      r.timer0_overflowed  = t0;
      r.cpu_idle           = idle;
      return r;
   endfunction

   // mostly ticks; write values cluster near a hot spot so compares actually hit
   function automatic pca_req_type random_beat(input logic [15:0] hot);
      pca_req_type r;
      int          pick;
      r.timer0_overflowed  = 1'($urandom);
      r.external_clock_pin = 1'($urandom);
      r.module_pins        = 5'($urandom);
      r.cpu_idle           = ($urandom_range(3) == 0);
      r.module_select      = 3'($urandom);
      r.write_value        = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) r.mode = ModeTick;
      else if (pick < 82) r.mode = ModeWriteCmp;
      else if (pick < 88) r.mode = ModeWriteFlags;
      else r.mode = ModeLoadCount;
      if (r.mode != ModeWriteFlags && $urandom_range(3) != 0)
         r.write_value = hot + 16'($urandom_range(48));
      return r;
   endfunction

   initial begin
      pca_cfg_type c;
      logic [15:0] hot;
      int          n_items;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wrap, watchdog, captures on both edges, PWM reload, odd writes
      program_csrs('{1'b1, 1'b1, ClkFast, 1'b1, '1});
      @(posedge clock);
      queue_beat(beat_of(ModeLoadCount, 3'd0, 16'hFFFE, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeWriteCmp, 3'd4, 16'h0001, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeWriteCmp, 3'd0, 16'hFFFF, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeTick, 3'd0, 16'h0000, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeTick, 3'd0, 16'h0000, 5'h00, 1'b1, 1'b0, 1'b1));
      queue_beat(beat_of(ModeTick, 3'd0, 16'h0000, 5'h1F, 1'b0, 1'b1, 1'b0));
      queue_beat(beat_of(ModeWriteFlags, 3'd7, 16'hFFFF, 5'h00, 1'b0, 1'b1, 1'b1));
      queue_beat(beat_of(ModeWriteFlags, 3'd0, 16'h0000, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeWriteCmp, 3'd5, 16'hABCD, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeWriteCmp, 3'd7, 16'hFFFF, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeWriteCmp, 3'd2, 16'h8040, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeLoadCount, 3'd0, 16'h00FD, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeTick, 3'd0, 16'h0000, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeTick, 3'd0, 16'h0000, 5'h1F, 1'b0, 1'b1, 1'b0));
      queue_beat(beat_of(ModeWriteCmp, 3'd3, 16'h0000, 5'h1F, 1'b0, 1'b0, 1'b0));
      queue_beat(beat_of(ModeLoadCount, 3'd0, 16'hFFFF, 5'h1F, 1'b0, 1'b0, 1'b0));
      queue_beat(beat_of(ModeTick, 3'd0, 16'h0000, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeLoadCount, 3'd0, 16'h0000, 5'h1F, 1'b1, 1'b0, 1'b0));
      queue_beat(beat_of(ModeTick, 3'd0, 16'hFFFF, 5'h15, 1'b1, 1'b1, 1'b1));

      for (int p = 0; p < 11; p++) begin
         wait_drained();
         c.counter_run     = ($urandom_range(7) != 0);
         c.idle_stop       = 1'($urandom);
         c.clock_source    = pca_clk_src_type'(p % 4);
         c.watchdog_enable = 1'($urandom);
         c.module_modes    = ModeWidth'($urandom);
         for (int n = 0; n < ModuleCount; n++)
            if ($urandom_range(3) != 0) c.module_modes[n*ModeBits + MbCmpEn] = 1'b1;
         if (p == 0) c = '{1'b0, 1'b0, ClkCycle, 1'b0, '0};
         if (p == 1) c = '{1'b1, 1'b1, ClkExtPin, 1'b1, '1};
         if (p == 3) c.module_modes = ModuleModesReset;
         program_csrs(c);
         @(posedge clock);
         quiet = (p == 5);
         case ($urandom_range(2))
            0: hot = 16'hFFE0;
            1: hot = {8'($urandom), 8'hE0};
            default: hot = 16'($urandom);
         endcase
         n_items = quiet ? 150 : 60;
         repeat (n_items) queue_beat(random_beat(hot));
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("%0d beats checked under %0d settings: %0d ticks, %0d counts,",
               beats_out, settings_run, ticks_seen, count_steps);
      $display("%0d watchdog matches, %0d mismatching fields", wd_seen, mismatches);
      if (mismatches == 0 && pca_outcomes.size() == 0) begin
         $display("pca_counter_capture_compare_unit: match");
      end else begin
         $display("pca_counter_capture_compare_unit: mismatch");
      end
      $finish;
   end

endmodule
